// ----- rtl/cbc_pkg.sv -----
// Shared types, codes and constants for the cartridge bank controller.
// No dependencies; every rtl file imports this package.
package cbc_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned ROM_BANK_W  = 8;
   localparam int unsigned RAM_BANK_W  = 2;
   localparam int unsigned RTC_SEL_W   = 3;
   localparam int unsigned ROM_ADDR_W  = 22;
   localparam int unsigned RAM_ADDR_W  = 15;
   localparam int unsigned ROM_OFS_W   = 14;   // 0x4000 bytes per ROM bank
   localparam int unsigned RAM_OFS_W   = 13;   // 0x2000 bytes per RAM bank

   // Access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Cartridge type codes
   localparam logic [7:0] CART_MBC1_LO = 8'h01;
   localparam logic [7:0] CART_MBC1_HI = 8'h03;
   localparam logic [7:0] CART_MBC3    = 8'h13;

   // 8 KiB regions of the lower 32 KiB, selected by address bits 14:13
   localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
   localparam logic [1:0] REG_ROM_BANK   = 2'd1;
   localparam logic [1:0] REG_UPPER_BANK = 2'd2;
   localparam logic [1:0] REG_MODE       = 2'd3;

   // Address bits 15:13 of the external RAM window 0xA000-0xBFFF
   localparam logic [2:0] RAM_WINDOW = 3'b101;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] RTC_SEL_FIRST  = 8'h08;
   localparam logic [7:0] RTC_SEL_LAST   = 8'h0C;
   localparam logic [7:0] RAM_SEL_LAST   = 8'h03;
   localparam logic [2:0] RTC_INDEX_MAX  = 3'd4;

   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_ROM  = 2'd1,
      TGT_RAM  = 2'd2,
      TGT_RTC  = 2'd3
   } target_type;

   typedef struct packed {
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      logic                  ram_enabled;
      logic                  ram_banking_mode;
      logic [RTC_SEL_W-1:0]  rtc_selected;
      logic                  rtc_mapped;
   } bank_state_type;

   typedef struct packed {
      target_type            target;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic [RAM_ADDR_W-1:0] ram_address;
      logic [RTC_SEL_W-1:0]  rtc_index;
      logic                  ram_write_strobe;
   } result_type;

   function automatic logic is_mbc1(input logic [7:0] cart_type);
      return (cart_type >= CART_MBC1_LO) && (cart_type <= CART_MBC1_HI);
   endfunction

   function automatic logic is_mbc3(input logic [7:0] cart_type);
      return cart_type == CART_MBC3;
   endfunction

endpackage

// ----- rtl/cbc_bank_regs.sv -----
// Banking register file: holds ROM/RAM bank, enables, mode and RTC select,
// and applies MBC1/MBC3 write rules. Depends on cbc_pkg.
module cbc_bank_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic [7:0]                   cart_type,
   input  logic [cbc_pkg::ADDR_W-1:0]   address,
   input  logic [cbc_pkg::DATA_W-1:0]   write_data,
   output cbc_pkg::bank_state_type      bank_state
);
   import cbc_pkg::*;

   bank_state_type state_ff, state_in;
   logic           mbc1, mbc3;
   logic [ROM_BANK_W-1:0] new_bank;
   logic           bank_write;

   assign mbc1 = is_mbc1(cart_type);
   assign mbc3 = is_mbc3(cart_type);

   always_comb begin
      state_in   = state_ff;
      new_bank   = state_ff.rom_bank;
      bank_write = 1'b0;
      if (update && !address[ADDR_W-1]) begin
         case (address[14:13])
            REG_RAM_ENABLE: begin
               if (mbc1 || mbc3) begin
                  state_in.ram_enabled = (write_data[3:0] == RAM_ENABLE_KEY);
               end
            end
            REG_ROM_BANK: begin
               if (mbc1) begin
                  new_bank   = {state_ff.rom_bank[7:5], write_data[4:0]};
                  bank_write = 1'b1;
               end else if (mbc3) begin
                  new_bank   = {state_ff.rom_bank[7], write_data[6:0]};
                  bank_write = 1'b1;
               end
            end
            REG_UPPER_BANK: begin
               if (mbc1) begin
                  if (!state_ff.ram_banking_mode) begin
                     new_bank = {state_ff.rom_bank[7], write_data[1:0],
                                 state_ff.rom_bank[4:0]};
                     bank_write = 1'b1;
                  end else begin
                     state_in.ram_bank = write_data[RAM_BANK_W-1:0];
                  end
               end else if (mbc3) begin
                  if (write_data <= RAM_SEL_LAST) begin
                     state_in.ram_bank   = write_data[RAM_BANK_W-1:0];
                     state_in.rtc_mapped = 1'b0;
                  end else if (write_data >= RTC_SEL_FIRST &&
                               write_data <= RTC_SEL_LAST) begin
                     state_in.rtc_selected = RTC_SEL_W'(write_data - RTC_SEL_FIRST);
                     state_in.rtc_mapped   = 1'b1;
                  end
               end
            end
            REG_MODE: begin
               if (mbc1) begin
                  state_in.ram_banking_mode = write_data[0];
               end
            end
            default: ;
         endcase
      end
      // bank zero maps to bank one
      if (bank_write) begin
         state_in.rom_bank = (new_bank == '0) ? ROM_BANK_W'(1) : new_bank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bank         <= ROM_BANK_W'(1);
         state_ff.ram_bank         <= '0;
         state_ff.ram_enabled      <= 1'b0;
         state_ff.ram_banking_mode <= 1'b1;
         state_ff.rtc_selected     <= '0;
         state_ff.rtc_mapped       <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign bank_state = state_ff;

endmodule

// ----- rtl/cbc_addr_map.sv -----
// Address mapper: turns one bus access and the current bank state into
// a ROM, RAM or RTC target. Pure combinational. Depends on cbc_pkg.
module cbc_addr_map (
   input  logic                         kind,
   input  logic [cbc_pkg::ADDR_W-1:0]   address,
   input  logic [7:0]                   cart_type,
   input  cbc_pkg::bank_state_type      bank_state,
   output cbc_pkg::result_type          result
);
   import cbc_pkg::*;

   logic in_ram;
   logic [RAM_ADDR_W-1:0] ram_a;

   assign in_ram = (address[15:13] == RAM_WINDOW);
   assign ram_a  = {bank_state.ram_bank, address[RAM_OFS_W-1:0]};

   always_comb begin
      result = '0;
      if (kind == KIND_READ) begin
         if (!address[15]) begin
            result.target = TGT_ROM;
            if (!address[14]) begin
               result.rom_address = ROM_ADDR_W'(address[ROM_OFS_W-1:0]);
            end else begin
               result.rom_address = {bank_state.rom_bank, address[ROM_OFS_W-1:0]};
            end
         end else if (in_ram) begin
            if (is_mbc3(cart_type) && bank_state.rtc_mapped) begin
               result.target    = TGT_RTC;
               result.rtc_index = bank_state.rtc_selected;
            end else begin
               result.target      = TGT_RAM;
               result.ram_address = ram_a;
            end
         end
      end else if (in_ram) begin
         result.target           = TGT_RAM;
         result.ram_address      = ram_a;
         result.ram_write_strobe = bank_state.ram_enabled;
      end
   end

endmodule

// ----- rtl/cartridge_bank_controller_unit.sv -----
// Cartridge bank controller (MBC1 / MBC3 rules), one bus access per transfer.
// A request transfer is captured in the input register and mapped into the result register,
// which drives the response. One access per cycle while rsp_tready does not stall; the single
// mapping/update stage lies between the two registers.
// Reset (synchronous, active high) empties both stages, clears cartridge type
// to 0 and returns the bank registers to ROM bank 1, RAM banking mode.
module cartridge_bank_controller_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] write_data
   input  logic        req_tuser,   // [0] kind (0 read, 1 write)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [21:0] rom_address, [36:22] ram_address,
                                    // [39:37] rtc_index, [40] ram_write_strobe,
                                    // [47:41] zero
   output logic [1:0]  rsp_tuser,   // [1:0] target
   // cartridge type register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import cbc_pkg::*;

   // input stage
   logic                  req_valid_ff;
   logic                  req_kind_ff;
   logic [ADDR_W-1:0]     req_addr_ff;
   logic [DATA_W-1:0]     req_data_ff;
   // result stage
   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   // cartridge type register
   logic [7:0]            cart_type_ff;

   logic                  advance;
   bank_state_type        bank_state;
   result_type            result;

   // Advance the input stage into the result stage when the result slot is
   // free or drains in this same cycle.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff <= '0;
      end else if (csr_valid) begin
         cart_type_ff <= csr_data;
      end
   end

   // Input register: capture on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_kind_ff <= req_tuser;
         req_addr_ff <= req_tdata[15:0];
         req_data_ff <= req_tdata[23:16];
      end
   end

   // Bank registers change only when the access moves to the result stage,
   // so each access sees the effect of every earlier one.
   cbc_bank_regs u_bank_regs (
      .clock      (clock),
      .reset      (reset),
      .update     (advance && (req_kind_ff == KIND_WRITE)),
      .cart_type  (cart_type_ff),
      .address    (req_addr_ff),
      .write_data (req_data_ff),
      .bank_state (bank_state)
   );

   cbc_addr_map u_addr_map (
      .kind       (req_kind_ff),
      .address    (req_addr_ff),
      .cart_type  (cart_type_ff),
      .bank_state (bank_state),
      .result     (result)
   );

   // Result register: hold until the response transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.target;
   assign rsp_tdata  = {7'd0, rsp_ff.ram_write_strobe, rsp_ff.rtc_index,
                        rsp_ff.ram_address, rsp_ff.rom_address};

   // ROM bank zero is always remapped to one.
   a_rom_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      bank_state.rom_bank != '0)
      else $error("ROM bank register holds zero");

   // A write strobe only goes with an external RAM target.
   a_strobe_is_ram: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ram_write_strobe |-> rsp_ff.target == TGT_RAM)
      else $error("RAM write strobe without RAM target");

   // RTC index stays within the five RTC registers.
   a_rtc_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.target == TGT_RTC |-> rsp_ff.rtc_index <= RTC_INDEX_MAX)
      else $error("RTC index out of range");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_ff))
      else $error("Response changed while stalled");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for cartridge_bank_controller_unit (MBC1 / MBC3 banking).
// Depends on rtl/cbc_pkg.sv and the unit itself; bus accesses stream in, mapped results are
// predicted in the bench and compared field by field against every response transfer.
module tb_top;
   import cbc_pkg::*;

   // One CPU bus access as it travels on the request channel
   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } bus_access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] address, [23:16] write_data
   logic        req_tuser = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [21:0] rom_address, [36:22] ram_address,
                                  // [39:37] rtc_index, [40] ram_write_strobe
   logic [1:0]  rsp_tuser;        // [1:0] target
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   // Bench copy of the banking registers and the cartridge type
   bank_state_type bank_regs;
   logic [7:0]     cart_type;

   bus_access_type pending_accesses[$];
   result_type     expected_mappings[$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned fail_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;

   cartridge_bank_controller_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Map one access and apply any bank register write it carries.
   function automatic result_type map_access(input logic kind, input logic [15:0] address,
                                             input logic [7:0] data);
      result_type mapped;
      logic       mbc1;
      logic       mbc3;
      logic [7:0] next_bank;
      mapped = '0;
      mbc1 = (cart_type >= CART_MBC1_LO) && (cart_type <= CART_MBC1_HI);
      mbc3 = (cart_type == CART_MBC3);
      next_bank = bank_regs.rom_bank;
      if (kind == KIND_READ) begin
         if (address[15:14] == 2'b00) begin
            // fixed bank 0 window
            mapped.target = TGT_ROM;
            mapped.rom_address = {6'd0, address};
         end else if (!address[15]) begin
            mapped.target = TGT_ROM;
            mapped.rom_address = {bank_regs.rom_bank, address[13:0]};
         end else if (address[15:13] == RAM_WINDOW) begin
            // RTC takes over the RAM window only under MBC3 with a register mapped
            if (mbc3 && bank_regs.rtc_mapped) begin
               mapped.target = TGT_RTC;
               mapped.rtc_index = bank_regs.rtc_selected;
            end else begin
               mapped.target = TGT_RAM;
               mapped.ram_address = {bank_regs.ram_bank, address[12:0]};
            end
         end
      end else if (!address[15]) begin
         case (address[14:13])
            REG_RAM_ENABLE: begin
               if (mbc1 || mbc3)
                  bank_regs.ram_enabled = (data[3:0] == RAM_ENABLE_KEY);
            end
            REG_ROM_BANK: begin
               if (mbc1)
                  next_bank = {bank_regs.rom_bank[7:5], data[4:0]};
               else if (mbc3)
                  next_bank = {bank_regs.rom_bank[7], data[6:0]};
            end
            REG_UPPER_BANK: begin
               if (mbc1) begin
                  if (!bank_regs.ram_banking_mode)
                     next_bank = {bank_regs.rom_bank[7], data[1:0], bank_regs.rom_bank[4:0]};
                  else
                     bank_regs.ram_bank = data[1:0];
               end else if (mbc3) begin
                  if (data <= RAM_SEL_LAST) begin
                     bank_regs.ram_bank = data[1:0];
                     bank_regs.rtc_mapped = 1'b0;
                  end else if (data >= RTC_SEL_FIRST && data <= RTC_SEL_LAST) begin
                     bank_regs.rtc_selected = 3'(data - RTC_SEL_FIRST);
                     bank_regs.rtc_mapped = 1'b1;
                  end
               end
            end
            default: begin
               // MBC3 latch writes and plain cartridges leave the mode alone
               if (mbc1)
                  bank_regs.ram_banking_mode = data[0];
            end
         endcase
         // bank 0 can never be selected into the switchable window
         bank_regs.rom_bank = (next_bank == 8'd0) ? 8'd1 : next_bank;
      end else if (address[15:13] == RAM_WINDOW) begin
         mapped.target = TGT_RAM;
         mapped.ram_address = {bank_regs.ram_bank, address[12:0]};
         mapped.ram_write_strobe = bank_regs.ram_enabled;
      end
      return mapped;
   endfunction

   // Request driver: predict on every accepted transfer, then present the next access
   // unless the sender idles this cycle.
   always @(posedge clock) begin : drive_requests
      bus_access_type next_access;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_mappings.push_back(map_access(req_tuser, req_tdata[15:0], req_tdata[23:16]));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_access = pending_accesses.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {next_access.write_data, next_access.address};
               req_tuser <= next_access.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Response monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_mappings.size() == 0) begin
            $error("response transfer with no access outstanding: tuser %0d tdata %h",
                   rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_mappings.pop_front();
            checked_count++;
            if (rsp_tuser !== want.target) begin
               $error("target: expected %0d, got %0d", want.target, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[21:0] !== want.rom_address) begin
               $error("rom_address: expected %h, got %h", want.rom_address, rsp_tdata[21:0]);
               fail_count++;
            end
            if (rsp_tdata[36:22] !== want.ram_address) begin
               $error("ram_address: expected %h, got %h", want.ram_address, rsp_tdata[36:22]);
               fail_count++;
            end
            if (rsp_tdata[39:37] !== want.rtc_index) begin
               $error("rtc_index: expected %0d, got %0d", want.rtc_index, rsp_tdata[39:37]);
               fail_count++;
            end
            if (rsp_tdata[40] !== want.ram_write_strobe) begin
               $error("ram_write_strobe: expected %0d, got %0d", want.ram_write_strobe,
                      rsp_tdata[40]);
               fail_count++;
            end
         end
      end
   end

   task automatic queue_access(input logic kind, input logic [15:0] address,
                               input logic [7:0] data);
      bus_access_type item;
      item.kind = kind;
      item.address = address;
      item.write_data = data;
      pending_accesses.push_back(item);
   endtask

   // Mostly well-formed banking traffic: register writes with meaningful values,
   // reads of both ROM windows and the RAM window, RAM writes, and some raw noise.
   function automatic bus_access_type random_access();
      bus_access_type item;
      int unsigned    pick;
      pick = $urandom_range(99);
      item.kind = KIND_READ;
      item.address = 16'($urandom_range(16'hFFFF));
      item.write_data = 8'($urandom_range(8'hFF));
      if (pick < 30) begin
         item.kind = KIND_WRITE;
         item.address = 16'($urandom_range(16'h7FFF));
         case ($urandom_range(3))
            0: item.write_data = {item.write_data[7:4], RAM_ENABLE_KEY};
            1: item.write_data = 8'($urandom_range(RAM_SEL_LAST));
            2: item.write_data = 8'($urandom_range(RTC_SEL_LAST, RTC_SEL_FIRST));
            default: ;
         endcase
      end else if (pick < 60) begin
         item.address = 16'($urandom_range(16'h7FFF));
      end else if (pick < 80) begin
         item.address = {RAM_WINDOW, 13'($urandom)};
      end else if (pick < 92) begin
         item.kind = KIND_WRITE;
         item.address = {RAM_WINDOW, 13'($urandom)};
      end else begin
         item.kind = 1'($urandom_range(1));
      end
      return item;
   endfunction

   // Hold until every queued access went out and every response came back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_tvalid || expected_mappings.size() != 0);
   endtask

   // Write the cartridge type; only ever called while the unit is idle.
   task automatic write_cart_type(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      cart_type = value;
   endtask

   // Global time limit, far above the slowest correct run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] cart_settings[10];
      int         phase_count;
      cart_settings = '{8'h13, 8'h01, 8'h00, 8'h13, 8'h03, 8'hFF, 8'h02, 8'h12, 8'h13, 8'h04};
      phase_count = 10;
      bank_regs = '{rom_bank: 8'd1, ram_bank: 2'd0, ram_enabled: 1'b0,
                    ram_banking_mode: 1'b1, rtc_selected: 3'd0, rtc_mapped: 1'b0};
      cart_type = 8'h00;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < phase_count; phase++) begin
         // Cycle the idling pattern: none, sender gaps, receiver stalls, both
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 47; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 47; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         write_cart_type(cart_settings[phase]);

         if (phase == 0) begin
            // Directed sweep under MBC3: window edges, unmapped areas, bank 0 fixup,
            // RTC read, RAM read while disabled, RAM write while RTC mapped
            queue_access(KIND_READ,  16'h0000, 8'h00);
            queue_access(KIND_READ,  16'h3FFF, 8'hFF);
            queue_access(KIND_READ,  16'h4000, 8'h00);
            queue_access(KIND_READ,  16'h7FFF, 8'h00);
            queue_access(KIND_READ,  16'h8000, 8'h00);
            queue_access(KIND_READ,  16'hA000, 8'h00);
            queue_access(KIND_READ,  16'hC000, 8'h00);
            queue_access(KIND_READ,  16'hFFFF, 8'hFF);
            queue_access(KIND_WRITE, 16'hA000, 8'hFF);
            queue_access(KIND_WRITE, 16'h0000, 8'h0A);
            queue_access(KIND_WRITE, 16'hBFFF, 8'h5A);
            queue_access(KIND_WRITE, 16'h2000, 8'h00);
            queue_access(KIND_READ,  16'h4001, 8'h00);
            queue_access(KIND_WRITE, 16'h3FFF, 8'hFF);
            queue_access(KIND_READ,  16'h7FFF, 8'h00);
            queue_access(KIND_WRITE, 16'h4000, 8'h0C);
            queue_access(KIND_READ,  16'hA123, 8'h00);
            queue_access(KIND_WRITE, 16'hBFFF, 8'h00);
            queue_access(KIND_WRITE, 16'h4000, 8'h05);
            queue_access(KIND_WRITE, 16'h5FFF, 8'h03);
            queue_access(KIND_READ,  16'hBFFF, 8'h00);
            queue_access(KIND_WRITE, 16'h6000, 8'h01);
            queue_access(KIND_WRITE, 16'h1FFF, 8'h00);
            queue_access(KIND_WRITE, 16'h9FFF, 8'hFF);
            queue_access(KIND_WRITE, 16'hFFFF, 8'h0A);
         end

         for (int n = 0; n < 38; n++) begin
            pending_accesses.push_back(random_access());
            // Mid-phase hold: let the sender go quiet until all responses are back
            if (phase == 2 && n == 18)
               wait_drained();
         end
         wait_drained();
      end

      repeat (6) @(negedge clock);
      $display("Covered %0d bus accesses over %0d cartridge type settings, %0d responses checked.",
               accepted_count, phase_count, checked_count);
      if (fail_count == 0 && expected_mappings.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cbc_pkg.sv
rtl/cbc_bank_regs.sv
rtl/cbc_addr_map.sv
rtl/cartridge_bank_controller_unit.sv
tb/tb_top.sv
